FILE: src/npsd_pkg.sv
// Shared types and constants of the nearest-point symbol demapper.
`default_nettype none

package npsd_pkg;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned SYM_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  localparam logic [MODE_W-1:0] MODE_BPSK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QPSK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SLICE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_GAIN = 2'd2;

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_DEMAP = 1'b1;

  localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_SEARCH;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd256;

  typedef struct packed {
    logic             valid;
    logic             load;
    logic             search;
    logic [IDX_W-1:0] idx;
    logic             found;
    logic [SYM_W-1:0] sym;
  } npsd_ctrl_t;

endpackage

`default_nettype wire

FILE: src/nearest_point_symbol_demapper.sv
// Top level of the nearest-point symbol demapper: configuration registers and cell chain.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-------------------------------------------
//  command   | in        | start_i, busy_o      | action_i, point_index_i, in_i_i, in_q_i
//  result    | out       | symbol_valid_o       | symbol_o
//  config    | in        | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One word is taken every clock cycle; busy_o stays low.
// A word runs through a two-stage front end and MAX_POINTS cells of three stages each,
// and its symbol leaves the last cell; load words give no symbol.
// Loads travel the chain in order with samples, so each sample sees the table as loaded
// before it. Reset clears the pipeline and the registers; table points hold no reset value.
// The result side cannot stall: each symbol stands for exactly one cycle.
`default_nettype none

module nearest_point_symbol_demapper #(
  parameter int unsigned MAX_POINTS   = 32,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic                                  action_i,
  input  wire logic [npsd_pkg::IDX_W-1:0]            point_index_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        in_i_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        in_q_i,
  output logic                                       symbol_valid_o,
  output logic [npsd_pkg::SYM_W-1:0]                 symbol_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [npsd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [npsd_pkg::CFG_W-1:0]            cfg_data_i
);
  import npsd_pkg::*;

  localparam int unsigned DIST_W = 2 * SAMPLE_WIDTH + 2;

  logic [MODE_W-1:0]  mode_q;
  logic [COUNT_W-1:0] count_q;
  logic [GAIN_W-1:0]  gain_q;

  npsd_ctrl_t                     ctrl_c [MAX_POINTS+1];
  logic signed [SAMPLE_WIDTH-1:0] x_i_c  [MAX_POINTS+1];
  logic signed [SAMPLE_WIDTH-1:0] x_q_c  [MAX_POINTS+1];
  logic [DIST_W-1:0]              dist_c [MAX_POINTS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RESET;
      count_q <= COUNT_RESET;
      gain_q  <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SLICE_MODE:  mode_q  <= cfg_data_i[MODE_W-1:0];
        REG_POINT_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        REG_SAMPLE_GAIN: gain_q  <= cfg_data_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  npsd_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .action_i      (action_i),
    .point_index_i (point_index_i),
    .in_i_i        (in_i_i),
    .in_q_i        (in_q_i),
    .mode_i        (mode_q),
    .gain_i        (gain_q),
    .ctrl_o        (ctrl_c[0]),
    .x_i_o         (x_i_c[0]),
    .x_q_o         (x_q_c[0])
  );

  assign dist_c[0] = '0;

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    npsd_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .CELL_INDEX   (k)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .point_count_i (count_q),
      .ctrl_i        (ctrl_c[k]),
      .x_i_i         (x_i_c[k]),
      .x_q_i         (x_q_c[k]),
      .dist_i        (dist_c[k]),
      .ctrl_o        (ctrl_c[k+1]),
      .x_i_o         (x_i_c[k+1]),
      .x_q_o         (x_q_c[k+1]),
      .dist_o        (dist_c[k+1])
    );
  end

  assign busy_o         = 1'b0;
  assign symbol_valid_o = ctrl_c[MAX_POINTS].valid && !ctrl_c[MAX_POINTS].load;
  assign symbol_o       = ctrl_c[MAX_POINTS].sym;

endmodule

`default_nettype wire

FILE: src/npsd_front.sv
// Front end: hard slicing, gain scaling and saturation of the incoming word.
`default_nettype none

module npsd_front #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic                                  action_i,
  input  wire logic [npsd_pkg::IDX_W-1:0]            point_index_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        in_i_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        in_q_i,
  input  wire logic [npsd_pkg::MODE_W-1:0]           mode_i,
  input  wire logic [npsd_pkg::GAIN_W-1:0]           gain_i,
  output npsd_pkg::npsd_ctrl_t                       ctrl_o,
  output logic signed [SAMPLE_WIDTH-1:0]             x_i_o,
  output logic signed [SAMPLE_WIDTH-1:0]             x_q_o
);
  import npsd_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_WIDTH + GAIN_W + 1;
  localparam int unsigned SHR_W  = PROD_W - 8;

  npsd_ctrl_t                      ctrl_d, ctrl_s1_q, ctrl_q;
  logic signed [SAMPLE_WIDTH-1:0]  raw_i_q, raw_q_q;
  logic signed [PROD_W-1:0]        prod_i_d, prod_q_d, prod_i_q, prod_q_q;
  logic signed [SAMPLE_WIDTH-1:0]  x_i_d, x_q_d, x_i_q, x_q_q;
  logic                            pos_i, pos_q;

  function automatic logic signed [SAMPLE_WIDTH-1:0] saturate(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [SHR_W-1:0]  r;
    logic [SHR_W-SAMPLE_WIDTH:0] top;
    r   = p[PROD_W-1:8];
    top = r[SHR_W-1:SAMPLE_WIDTH-1];
    if ((&top) || !(|top)) begin
      saturate = r[SAMPLE_WIDTH-1:0];
    end else if (r[SHR_W-1]) begin
      saturate = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      saturate = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  endfunction

  assign pos_i = !in_i_i[SAMPLE_WIDTH-1] && (|in_i_i);
  assign pos_q = !in_q_i[SAMPLE_WIDTH-1] && (|in_q_i);

  always_comb begin
    ctrl_d        = '0;
    ctrl_d.valid  = start_i;
    ctrl_d.load   = (action_i == ACTION_LOAD);
    ctrl_d.search = (action_i == ACTION_DEMAP) && (mode_i == MODE_SEARCH);
    ctrl_d.idx    = point_index_i;
    ctrl_d.found  = 1'b0;
    unique case (mode_i)
      MODE_BPSK: ctrl_d.sym = {{(SYM_W-1){1'b0}}, pos_i};
      MODE_QPSK: ctrl_d.sym = {{(SYM_W-2){1'b0}}, pos_q, pos_i};
      default:   ctrl_d.sym = '0;
    endcase
  end

  assign prod_i_d = in_i_i * $signed({1'b0, gain_i});
  assign prod_q_d = in_q_i * $signed({1'b0, gain_i});

  always_comb begin
    if (ctrl_s1_q.load) begin
      x_i_d = raw_i_q;
      x_q_d = raw_q_q;
    end else begin
      x_i_d = saturate(prod_i_q);
      x_q_d = saturate(prod_q_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_s1_q <= '0;
      ctrl_q    <= '0;
    end else begin
      ctrl_s1_q <= ctrl_d;
      ctrl_q    <= ctrl_s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_i_q  <= in_i_i;
    raw_q_q  <= in_q_i;
    prod_i_q <= prod_i_d;
    prod_q_q <= prod_q_d;
    x_i_q    <= x_i_d;
    x_q_q    <= x_q_d;
  end

  assign ctrl_o = ctrl_q;
  assign x_i_o  = x_i_q;
  assign x_q_o  = x_q_q;

endmodule

`default_nettype wire

FILE: src/npsd_cell.sv
// One chain cell: holds a table point and folds its distance into the running best.
`default_nettype none

module npsd_cell #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned CELL_INDEX   = 0
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [npsd_pkg::COUNT_W-1:0]          point_count_i,
  input  wire npsd_pkg::npsd_ctrl_t                  ctrl_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        x_i_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        x_q_i,
  input  wire logic [2*SAMPLE_WIDTH+1:0]             dist_i,
  output npsd_pkg::npsd_ctrl_t                       ctrl_o,
  output logic signed [SAMPLE_WIDTH-1:0]             x_i_o,
  output logic signed [SAMPLE_WIDTH-1:0]             x_q_o,
  output logic [2*SAMPLE_WIDTH+1:0]                  dist_o
);
  import npsd_pkg::*;

  localparam int unsigned DIFF_W = SAMPLE_WIDTH + 1;
  localparam int unsigned DIST_W = 2 * SAMPLE_WIDTH + 2;
  localparam logic [IDX_W:0]   CELL_TAG = (IDX_W + 1)'(CELL_INDEX);
  localparam logic [SYM_W-1:0] CELL_SYM = SYM_W'(CELL_INDEX);
  localparam logic [COUNT_W-1:0] CELL_POS = COUNT_W'(CELL_INDEX);

  logic signed [SAMPLE_WIDTH-1:0] pt_i_q, pt_q_q;
  logic                           hit;

  npsd_ctrl_t                     ctrl_a_q, ctrl_b_q, ctrl_c_d, ctrl_c_q;
  logic signed [SAMPLE_WIDTH-1:0] x_i_a_q, x_q_a_q, x_i_b_q, x_q_b_q, x_i_c_q, x_q_c_q;
  logic [DIST_W-1:0]              dist_a_q, dist_b_q, dist_c_d, dist_c_q;
  logic signed [DIFF_W-1:0]       di_d, dq_d, di_a_q, dq_a_q;
  logic signed [DIST_W-1:0]       sqi_d, sqq_d;
  logic [DIST_W-1:0]              sqi_b_q, sqq_b_q, sum;
  logic                           take;

  assign hit = ctrl_i.valid && ctrl_i.load && ({1'b0, ctrl_i.idx} == CELL_TAG);

  assign di_d = DIFF_W'(x_i_i) - DIFF_W'(pt_i_q);
  assign dq_d = DIFF_W'(x_q_i) - DIFF_W'(pt_q_q);

  assign sqi_d = DIST_W'(di_a_q) * DIST_W'(di_a_q);
  assign sqq_d = DIST_W'(dq_a_q) * DIST_W'(dq_a_q);

  assign sum  = sqi_b_q + sqq_b_q;
  assign take = ctrl_b_q.search && (point_count_i > CELL_POS)
                && (!ctrl_b_q.found || (sum < dist_b_q));

  always_comb begin
    ctrl_c_d = ctrl_b_q;
    dist_c_d = dist_b_q;
    if (take) begin
      ctrl_c_d.found = 1'b1;
      ctrl_c_d.sym   = CELL_SYM;
      dist_c_d       = sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      pt_i_q <= x_i_i;
      pt_q_q <= x_q_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
      ctrl_b_q <= '0;
      ctrl_c_q <= '0;
    end else begin
      ctrl_a_q <= ctrl_i;
      ctrl_b_q <= ctrl_a_q;
      ctrl_c_q <= ctrl_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_i_a_q  <= x_i_i;
    x_q_a_q  <= x_q_i;
    dist_a_q <= dist_i;
    di_a_q   <= di_d;
    dq_a_q   <= dq_d;
    x_i_b_q  <= x_i_a_q;
    x_q_b_q  <= x_q_a_q;
    dist_b_q <= dist_a_q;
    sqi_b_q  <= sqi_d;
    sqq_b_q  <= sqq_d;
    x_i_c_q  <= x_i_b_q;
    x_q_c_q  <= x_q_b_q;
    dist_c_q <= dist_c_d;
  end

  assign ctrl_o = ctrl_c_q;
  assign x_i_o  = x_i_c_q;
  assign x_q_o  = x_q_c_q;
  assign dist_o = dist_c_q;

endmodule

`default_nettype wire
